// ===== sv/lfuc_pkg.sv =====
package lfuc_pkg;

	// geometry
	localparam int NUM_SETS = 8;
	localparam int MAX_WAYS = 8;
	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CNT_W = $clog2(MAX_WAYS + 1);

	// field widths
	localparam int KEY_W = 31;
	localparam int WORD_W = 32;
	localparam int WAYS_CFG_W = 4;

	localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = WAYS_CFG_W'(8);
	localparam logic [WORD_W-1:0] WORD_MAX = '1;

	// request kinds
	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_INSERT = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [KEY_W-1:0]  key;
		logic [WORD_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [WORD_W-1:0] value_out;
		logic              evicted;
		logic [KEY_W-1:0]  evicted_key;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [WORD_W-1:0] value;
		logic [WORD_W-1:0] uses;
		logic [WORD_W-1:0] stamp;
	} entry_t;

	// one set row, way 0 in the low slot
	typedef entry_t [MAX_WAYS-1:0] row_t;

	// add one, stop at all ones
	function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
		return (v == WORD_MAX) ? v : v + 1'b1;
	endfunction

endpackage

// ===== sv/lfuc_victim.sv =====
module lfuc_victim (
	input  logic                        clk,
	input  lfuc_pkg::row_t              row,
	input  logic [lfuc_pkg::MAX_WAYS-1:0] vld,
	output logic [lfuc_pkg::WAY_W-1:0]  victim
);
	import lfuc_pkg::*;

	localparam int LEAVES = 2 ** WAY_W;
	localparam int NQ = (WAY_W > 1) ? WAY_W - 1 : 1;

	typedef struct packed {
		logic              vld;
		logic [WORD_W-1:0] uses;
		logic [WORD_W-1:0] stamp;
		logic [WAY_W-1:0]  idx;
	} node_t;

	node_t leaf [LEAVES];
	node_t cmb [WAY_W][LEAVES/2];
	node_t node_q [NQ][LEAVES];

	// right side wins only when valid and strictly lower in (uses, stamp)
	function automatic node_t pick(input node_t a, input node_t b);
		logic take_b;
		take_b = b.vld && (!a.vld || (b.uses < a.uses) ||
			((b.uses == a.uses) && (b.stamp < a.stamp)));
		return take_b ? b : a;
	endfunction

	// build leaves and combine one tree level per stage
	always_comb begin
		node_t a;
		node_t b;
		for (int i = 0; i < LEAVES; i++) begin
			leaf[i] = '0;
			if (i < MAX_WAYS) begin
				leaf[i].vld = vld[(i < MAX_WAYS) ? i : 0];
				leaf[i].uses = row[(i < MAX_WAYS) ? i : 0].uses;
				leaf[i].stamp = row[(i < MAX_WAYS) ? i : 0].stamp;
				leaf[i].idx = WAY_W'(i);
			end
		end
		for (int l = 0; l < WAY_W; l++) begin
			for (int k = 0; k < LEAVES / 2; k++) begin
				cmb[l][k] = '0;
				if (k < (LEAVES >> (l + 1))) begin
					a = (l == 0) ? leaf[2*k] : node_q[(l == 0) ? 0 : l - 1][2*k];
					b = (l == 0) ? leaf[2*k+1] : node_q[(l == 0) ? 0 : l - 1][2*k+1];
					cmb[l][k] = pick(a, b);
				end
			end
		end
	end

	// register every level but the last
	always_ff @(posedge clk) begin
		for (int l = 0; l < NQ; l++) begin
			for (int k = 0; k < LEAVES; k++) begin
				if ((l < WAY_W - 1) && (k < LEAVES / 2)) begin
					node_q[l][k] <= cmb[(l < WAY_W) ? l : 0][(k < LEAVES / 2) ? k : 0];
				end else begin
					node_q[l][k] <= '0;
				end
			end
		end
	end

	assign victim = cmb[WAY_W-1][0].idx;

endmodule

// ===== sv/lfu_set_associative_cache.sv =====
// LFU set-associative cache: one set row is read and compared per request, and written back on a hit or an insert.
// The response follows the row read, two registered levels of the victim min-tree, and
// the write-back, which registers the response.
// A new request is not accepted before the previous one is through: the input stalls until write-back ends, and
// write-back waits while an earlier response is still stalled.
// Reset clears the valid bits and tick counter and sets the way limit ways_q to 8; rows keep contents.
module lfu_set_associative_cache (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  lfuc_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output lfuc_pkg::rsp_t                rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lfuc_pkg::WAYS_CFG_W-1:0] cfg_data
);
	import lfuc_pkg::*;

	localparam logic [WAY_W-1:0] CMP_LAST = WAY_W'((WAY_W >= 2) ? WAY_W - 2 : 0);
	localparam logic [CNT_W-1:0] WAYS_MAX = CNT_W'(MAX_WAYS);

	typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_WB} state_t;

	state_t               state_q;
	logic [WAY_W-1:0]     stg_q;
	logic [WAYS_CFG_W-1:0] ways_q;
	logic [WORD_W-1:0]    tick_q;
	logic [MAX_WAYS-1:0]  valid_q [NUM_SETS];

	row_t                 row_mem [NUM_SETS];
	row_t                 row_s1;
	req_t                 req_s1;
	logic [SET_W-1:0]     set_in;
	logic [SET_W-1:0]     set_s1;

	logic                 accept;
	logic                 wb_done;
	logic                 wr_en;
	logic [MAX_WAYS-1:0]  vld_cur;
	logic [MAX_WAYS-1:0]  vld_new;
	logic [CNT_W-1:0]     occ;
	logic [CNT_W-1:0]     ways_eff;
	logic                 full;
	logic                 hit_any;
	logic [WAY_W-1:0]     hit_idx;
	logic [WAY_W-1:0]     victim;
	logic [WORD_W-1:0]    tick_new;
	logic [WORD_W-1:0]    tick_upd;
	entry_t               ent_new;
	row_t                 row_new;
	rsp_t                 rsp_new;

	// handshakes
	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign wb_done = (state_q == ST_WB) && (!rsp_valid || !rsp_stall);
	assign cfg_ready = 1'b1;
	assign set_in = SET_W'(req.key % NUM_SETS);

	// row memory: read on accept, write back on leaving write-back when wr_en is set
	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1 <= row_mem[set_in];
		end
		if (wb_done && wr_en) begin
			row_mem[set_s1] <= row_new;
		end
	end

	// hold the request
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
			set_s1 <= set_in;
		end
	end

	assign vld_cur = valid_q[set_s1];

	lfuc_victim u_victim (
		.clk   (clk),
		.row   (row_s1),
		.vld   (vld_cur),
		.victim(victim)
	);

	// occupancy and clamped way limit
	always_comb begin
		occ = CNT_W'($countones(vld_cur));
		if (32'(ways_q) > 32'(MAX_WAYS)) begin
			ways_eff = WAYS_MAX;
		end else begin
			ways_eff = CNT_W'(ways_q);
		end
		full = (occ >= ways_eff) && (occ != '0);
	end

	// earliest matching valid way
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (vld_cur[i] && (row_s1[i].key == req_s1.key)) begin
				hit_any = 1'b1;
				hit_idx = WAY_W'(i);
			end
		end
	end

	// build the new row, valid bits and response
	always_comb begin
		tick_new = sat_inc(tick_q);
		ent_new.key = req_s1.key;
		ent_new.value = req_s1.value_in;
		ent_new.uses = '0;
		ent_new.stamp = tick_new;
		row_new = row_s1;
		vld_new = vld_cur;
		rsp_new = '0;
		wr_en = 1'b0;
		tick_upd = tick_q;
		if (ways_eff != '0) begin
			if (req_s1.req_type == REQ_LOOKUP) begin
				if (hit_any) begin
					wr_en = 1'b1;
					row_new[hit_idx].uses = sat_inc(row_s1[hit_idx].uses);
					row_new[hit_idx].stamp = tick_new;
					rsp_new.hit = 1'b1;
					rsp_new.value_out = row_s1[hit_idx].value;
				end
			end else begin
				wr_en = 1'b1;
				tick_upd = tick_new;
				if (full) begin
					// drop the victim, close the gap, append at the top
					rsp_new.evicted = 1'b1;
					rsp_new.evicted_key = row_s1[victim].key;
					for (int i = 0; i < MAX_WAYS; i++) begin
						if (i >= victim) begin
							if (i + 1 < occ) begin
								row_new[i] = row_s1[(i < MAX_WAYS - 1) ? i + 1 : i];
							end else if (i + 1 == occ) begin
								row_new[i] = ent_new;
							end
						end
					end
				end else begin
					row_new[occ[WAY_W-1:0]] = ent_new;
					vld_new[occ[WAY_W-1:0]] = 1'b1;
				end
			end
		end
	end

	// sequencer, valid bits, tick and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stg_q <= '0;
			ways_q <= WAYS_RESET;
			tick_q <= '0;
			for (int s = 0; s < NUM_SETS; s++) begin
				valid_q[s] <= '0;
			end
			rsp_valid <= 1'b0;
			rsp <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ways_q <= cfg_data;
			end
			// drop the taken response unless write-back replaces it
			if (rsp_valid && !rsp_stall && !wb_done) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CMP;
						stg_q <= CMP_LAST;
					end
				end
				ST_CMP: begin
					if (stg_q == '0) begin
						state_q <= ST_WB;
					end else begin
						stg_q <= stg_q - 1'b1;
					end
				end
				ST_WB: begin
					if (wb_done) begin
						rsp_valid <= 1'b1;
						rsp <= rsp_new;
						tick_q <= tick_upd;
						valid_q[set_s1] <= vld_new;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
